// ----- rtl/integer_alu_hi_lo_trap_core_assert.svh -----
// Assertion macros shared by the integer ALU RTL.
`ifndef INTEGER_ALU_HI_LO_TRAP_CORE_ASSERT_SVH
`define INTEGER_ALU_HI_LO_TRAP_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define IAHL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define IAHL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/iahl_pkg.sv -----
// Shared types, operation codes and helpers for the integer ALU.
package iahl_pkg;

   localparam int unsigned XlenC   = 64;
   localparam int unsigned HalfC   = 32;
   localparam int unsigned ShMaxC  = 63;

   typedef enum logic [5:0] {
      OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_AND = 6'd2, OP_BREAK = 6'd3,
      OP_DADD = 6'd4, OP_DADDU = 6'd5, OP_DDIV = 6'd6, OP_DDIVU = 6'd7,
      OP_DIV = 6'd8, OP_DIVU = 6'd9, OP_DMULT = 6'd10, OP_DMULTU = 6'd11,
      OP_DSLL = 6'd12, OP_DSLL32 = 6'd13, OP_DSLLV = 6'd14, OP_DSRA = 6'd15,
      OP_DSRA32 = 6'd16, OP_DSRAV = 6'd17, OP_DSRL = 6'd18, OP_DSRL32 = 6'd19,
      OP_DSRLV = 6'd20, OP_DSUB = 6'd21, OP_DSUBU = 6'd22, OP_MFHI = 6'd23,
      OP_MFLO = 6'd24, OP_MTHI = 6'd25, OP_MTLO = 6'd26, OP_MULT = 6'd27,
      OP_MULTU = 6'd28, OP_NOR = 6'd29, OP_OR = 6'd30, OP_SLL = 6'd31,
      OP_SLLV = 6'd32, OP_SLT = 6'd33, OP_SLTU = 6'd34, OP_SRA = 6'd35,
      OP_SRAV = 6'd36, OP_SRL = 6'd37, OP_SRLV = 6'd38, OP_SUB = 6'd39,
      OP_SUBU = 6'd40, OP_SYNC = 6'd41, OP_SYSCALL = 6'd42, OP_TEQ = 6'd43,
      OP_TGE = 6'd44, OP_TGEU = 6'd45, OP_TLT = 6'd46, OP_TLTU = 6'd47,
      OP_TNE = 6'd48, OP_XOR = 6'd49
   } op_type;

   typedef enum logic [2:0] {
      EXC_NONE = 3'd0, EXC_OVERFLOW = 3'd1, EXC_BREAK = 3'd2,
      EXC_SYSCALL = 3'd3, EXC_TRAP = 3'd4
   } exc_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_ITER, ST_FIX, ST_DONE
   } state_type;

   function automatic logic [63:0] sx32(input logic [31:0] x);
      sx32 = {{32{x[31]}}, x};
   endfunction

endpackage

// ----- rtl/integer_alu_hi_lo_trap_core.sv -----
// Integer ALU for the special instruction group with HI/LO and traps.
// Simple ops: the accepted word goes through exec to done, where the result is valid;
// a new word is taken only once the result is taken and the core is back in idle.
// Multiply and divide: 64 one-bit iterations on a shared 65-bit add/subtract unit
// plus a sign-fix step (iter, fix, done); a zero divisor goes from exec straight to done.
// req_tready is high only in idle; synchronous reset clears control state and HI/LO.
`include "integer_alu_hi_lo_trap_core_assert.svh"

module integer_alu_hi_lo_trap_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // op[5:0], rs_value[69:6], rt_value[133:70], shift_amount[138:134], zero pad
   input  logic [143:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // rd_result[63:0], rd_write[64], exception_code[67:65], zero pad
   output logic [71:0]   rsp_tdata
);

   iahl_pkg::state_type state_ff, state_in;
   logic [5:0]  op_ff, op_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [4:0]  sa_ff, sa_in;
   logic [63:0] hi_ff, hi_in, lo_ff, lo_in;
   // acc: partial remainder / product high; q: quotient / multiplier low
   logic [63:0] acc_ff, acc_in, q_ff, q_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, is_div_ff, is_div_in;
   logic        w32_ff, w32_in;
   logic [63:0] res_ff, res_in;
   logic        wr_ff, wr_in;
   logic [2:0]  exc_ff, exc_in;
   logic        busy_ff, busy_in;

   // shared unit
   logic [64:0] alu_x, alu_y, alu_sum;
   logic        alu_sub;

   assign alu_sum = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iahl_pkg::ST_IDLE;
         hi_ff    <= '0;
         lo_ff    <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         busy_ff  <= busy_in;
      end
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; sa_ff <= sa_in;
      acc_ff <= acc_in; q_ff <= q_in; cnt_ff <= cnt_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; is_div_ff <= is_div_in;
      w32_ff <= w32_in;
      res_ff <= res_in; wr_ff <= wr_in; exc_ff <= exc_in;
   end

   always_comb begin
      logic [63:0] sh_src, r, ma, mb;
      logic [5:0]  sh;
      logic        ovf, lt_s, lt_u, eq, sra_op, srl_op, sll_op, s32, w32;
      logic [31:0] b32s;
      logic [127:0] prod;
      iahl_pkg::op_type op;

      state_in = state_ff;
      op_in = op_ff; a_in = a_ff; b_in = b_ff; sa_in = sa_ff;
      hi_in = hi_ff; lo_in = lo_ff; acc_in = acc_ff; q_in = q_ff; cnt_in = cnt_ff;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; is_div_in = is_div_ff;
      w32_in = w32_ff;
      res_in = res_ff; wr_in = wr_ff; exc_in = exc_ff; busy_in = busy_ff;
      alu_x = '0; alu_y = '0; alu_sub = 1'b0;
      req_tready = 1'b0;
      sh_src = '0; sh = '0; r = '0; ovf = 1'b0; sra_op = 1'b0; srl_op = 1'b0;
      sll_op = 1'b0; s32 = 1'b0; b32s = '0; ma = '0; mb = '0; prod = '0; w32 = 1'b0;
      op = iahl_pkg::op_type'(op_ff);
      lt_s = 1'b0; lt_u = 1'b0; eq = 1'b0;

      unique case (state_ff)
         iahl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = req_tdata[5:0];
               a_in  = req_tdata[69:6];
               b_in  = req_tdata[133:70];
               sa_in = req_tdata[138:134];
               busy_in = 1'b1;
               state_in = iahl_pkg::ST_EXEC;
            end
         end
         iahl_pkg::ST_EXEC: begin
            wr_in = 1'b0; exc_in = iahl_pkg::EXC_NONE; res_in = '0;
            // compare flags via the shared subtract
            alu_x = {1'b0, a_ff}; alu_y = {1'b0, b_ff}; alu_sub = 1'b1;
            lt_u = alu_sum[64];
            eq   = (a_ff == b_ff);
            lt_s = (a_ff[63] != b_ff[63]) ? a_ff[63] : lt_u;
            s32 = 1'b0;
            unique case (op)
               iahl_pkg::OP_DSUB, iahl_pkg::OP_DSUBU, iahl_pkg::OP_SUB,
               iahl_pkg::OP_SUBU: alu_sub = 1'b1;
               iahl_pkg::OP_ADD, iahl_pkg::OP_ADDU, iahl_pkg::OP_DADD,
               iahl_pkg::OP_DADDU: alu_sub = 1'b0;
               default: alu_sub = 1'b1;
            endcase
            r = alu_sum[63:0];
            state_in = iahl_pkg::ST_DONE;
            unique case (op)
               iahl_pkg::OP_ADD, iahl_pkg::OP_ADDU, iahl_pkg::OP_SUB,
               iahl_pkg::OP_SUBU: begin
                  res_in = iahl_pkg::sx32(r[31:0]);
                  ovf = alu_sub ? ((a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ r[31]))
                                : (~(a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ r[31]));
                  if (ovf && (op == iahl_pkg::OP_ADD || op == iahl_pkg::OP_SUB)) begin
                     exc_in = iahl_pkg::EXC_OVERFLOW;
                  end else begin
                     wr_in = 1'b1;
                  end
               end
               iahl_pkg::OP_DADD, iahl_pkg::OP_DADDU, iahl_pkg::OP_DSUB,
               iahl_pkg::OP_DSUBU: begin
                  res_in = r;
                  ovf = alu_sub ? ((a_ff[63] ^ b_ff[63]) & (a_ff[63] ^ r[63]))
                                : (~(a_ff[63] ^ b_ff[63]) & (a_ff[63] ^ r[63]));
                  if (ovf && (op == iahl_pkg::OP_DADD || op == iahl_pkg::OP_DSUB)) begin
                     exc_in = iahl_pkg::EXC_OVERFLOW;
                  end else begin
                     wr_in = 1'b1;
                  end
               end
               iahl_pkg::OP_AND: begin res_in = a_ff & b_ff; wr_in = 1'b1; end
               iahl_pkg::OP_OR:  begin res_in = a_ff | b_ff; wr_in = 1'b1; end
               iahl_pkg::OP_XOR: begin res_in = a_ff ^ b_ff; wr_in = 1'b1; end
               iahl_pkg::OP_NOR: begin res_in = ~(a_ff | b_ff); wr_in = 1'b1; end
               iahl_pkg::OP_BREAK:   exc_in = iahl_pkg::EXC_BREAK;
               iahl_pkg::OP_SYSCALL: exc_in = iahl_pkg::EXC_SYSCALL;
               iahl_pkg::OP_SYNC: ;
               iahl_pkg::OP_SLT:  begin res_in = {63'd0, lt_s}; wr_in = 1'b1; end
               iahl_pkg::OP_SLTU: begin res_in = {63'd0, lt_u}; wr_in = 1'b1; end
               iahl_pkg::OP_TEQ:  if (eq)    exc_in = iahl_pkg::EXC_TRAP;
               iahl_pkg::OP_TNE:  if (!eq)   exc_in = iahl_pkg::EXC_TRAP;
               iahl_pkg::OP_TGE:  if (!lt_s) exc_in = iahl_pkg::EXC_TRAP;
               iahl_pkg::OP_TGEU: if (!lt_u) exc_in = iahl_pkg::EXC_TRAP;
               iahl_pkg::OP_TLT:  if (lt_s)  exc_in = iahl_pkg::EXC_TRAP;
               iahl_pkg::OP_TLTU: if (lt_u)  exc_in = iahl_pkg::EXC_TRAP;
               iahl_pkg::OP_MFHI: begin res_in = hi_ff; wr_in = 1'b1; end
               iahl_pkg::OP_MFLO: begin res_in = lo_ff; wr_in = 1'b1; end
               iahl_pkg::OP_MTHI: hi_in = a_ff;
               iahl_pkg::OP_MTLO: lo_in = a_ff;
               iahl_pkg::OP_DSLL, iahl_pkg::OP_DSLL32, iahl_pkg::OP_DSLLV,
               iahl_pkg::OP_DSRA, iahl_pkg::OP_DSRA32, iahl_pkg::OP_DSRAV,
               iahl_pkg::OP_DSRL, iahl_pkg::OP_DSRL32, iahl_pkg::OP_DSRLV,
               iahl_pkg::OP_SLL, iahl_pkg::OP_SLLV, iahl_pkg::OP_SRA,
               iahl_pkg::OP_SRAV, iahl_pkg::OP_SRL, iahl_pkg::OP_SRLV: begin
                  sll_op = (op == iahl_pkg::OP_DSLL) || (op == iahl_pkg::OP_DSLL32)
                        || (op == iahl_pkg::OP_DSLLV) || (op == iahl_pkg::OP_SLL)
                        || (op == iahl_pkg::OP_SLLV);
                  sra_op = (op == iahl_pkg::OP_DSRA) || (op == iahl_pkg::OP_DSRA32)
                        || (op == iahl_pkg::OP_DSRAV) || (op == iahl_pkg::OP_SRA)
                        || (op == iahl_pkg::OP_SRAV);
                  srl_op = !sll_op && !sra_op;
                  s32 = (op == iahl_pkg::OP_SLL) || (op == iahl_pkg::OP_SLLV)
                     || (op == iahl_pkg::OP_SRA) || (op == iahl_pkg::OP_SRAV)
                     || (op == iahl_pkg::OP_SRL) || (op == iahl_pkg::OP_SRLV);
                  if (op == iahl_pkg::OP_DSLL32 || op == iahl_pkg::OP_DSRA32
                      || op == iahl_pkg::OP_DSRL32) begin
                     sh = {1'b1, sa_ff};
                  end else if (op == iahl_pkg::OP_DSLLV || op == iahl_pkg::OP_DSRAV
                      || op == iahl_pkg::OP_DSRLV) begin
                     sh = a_ff[5:0];
                  end else if (op == iahl_pkg::OP_SLLV || op == iahl_pkg::OP_SRAV
                      || op == iahl_pkg::OP_SRLV) begin
                     sh = {1'b0, a_ff[4:0]};
                  end else begin
                     sh = {1'b0, sa_ff};
                  end
                  b32s = b_ff[31:0];
                  if (s32) begin
                     sh_src = sra_op ? iahl_pkg::sx32(b32s) : {32'd0, b32s};
                  end else begin
                     sh_src = b_ff;
                  end
                  if (sll_op) begin
                     r = sh_src << sh;
                  end else if (sra_op) begin
                     r = $unsigned($signed(sh_src) >>> sh);
                  end else begin
                     r = sh_src >> sh;
                  end
                  res_in = s32 ? iahl_pkg::sx32(r[31:0]) : r;
                  wr_in = 1'b1;
                  if (srl_op) ;
               end
               iahl_pkg::OP_MULT, iahl_pkg::OP_MULTU, iahl_pkg::OP_DMULT,
               iahl_pkg::OP_DMULTU, iahl_pkg::OP_DIV, iahl_pkg::OP_DIVU,
               iahl_pkg::OP_DDIV, iahl_pkg::OP_DDIVU: begin
                  is_div_in = (op == iahl_pkg::OP_DIV) || (op == iahl_pkg::OP_DIVU)
                           || (op == iahl_pkg::OP_DDIV) || (op == iahl_pkg::OP_DDIVU);
                  w32 = (op == iahl_pkg::OP_DIV) || (op == iahl_pkg::OP_DIVU)
                     || (op == iahl_pkg::OP_MULT) || (op == iahl_pkg::OP_MULTU);
                  w32_in = w32;
                  ma = w32 ? iahl_pkg::sx32(a_ff[31:0]) : a_ff;
                  mb = w32 ? iahl_pkg::sx32(b_ff[31:0]) : b_ff;
                  if (op == iahl_pkg::OP_DIVU || op == iahl_pkg::OP_MULTU) begin
                     ma = {32'd0, a_ff[31:0]}; mb = {32'd0, b_ff[31:0]};
                  end
                  s32 = (op == iahl_pkg::OP_DIV) || (op == iahl_pkg::OP_DDIV)
                     || (op == iahl_pkg::OP_MULT) || (op == iahl_pkg::OP_DMULT);
                  // work on magnitudes, fix signs at the end
                  neg_q_in = s32 && (ma[63] ^ mb[63]);
                  neg_r_in = s32 && ma[63];
                  if (s32 && ma[63]) ma = -ma;
                  if (s32 && mb[63]) mb = -mb;
                  a_in = mb;      // divisor / multiplicand magnitude
                  q_in = ma;      // dividend / multiplier magnitude
                  acc_in = '0;
                  cnt_in = 7'd64;
                  if (is_div_in && mb == 64'd0) begin
                     state_in = iahl_pkg::ST_DONE;
                  end else begin
                     state_in = iahl_pkg::ST_ITER;
                  end
               end
               default: ;
            endcase
            if (!wr_in) res_in = '0;
         end
         iahl_pkg::ST_ITER: begin
            cnt_in = cnt_ff - 7'd1;
            if (is_div_ff) begin
               // restoring division, one quotient bit per cycle
               alu_x = {acc_ff, q_ff[63]}; alu_y = {1'b0, a_ff}; alu_sub = 1'b1;
               if (!alu_sum[64]) begin
                  acc_in = alu_sum[63:0]; q_in = {q_ff[62:0], 1'b1};
               end else begin
                  acc_in = {acc_ff[62:0], q_ff[63]}; q_in = {q_ff[62:0], 1'b0};
               end
            end else begin
               // shift-add multiply, LSB first
               alu_x = {1'b0, acc_ff}; alu_y = q_ff[0] ? {1'b0, a_ff} : '0;
               alu_sub = 1'b0;
               acc_in = alu_sum[64:1]; q_in = {alu_sum[0], q_ff[63:1]};
            end
            if (cnt_ff == 7'd1) state_in = iahl_pkg::ST_FIX;
         end
         iahl_pkg::ST_FIX: begin
            if (is_div_ff) begin
               ma = neg_q_ff ? -q_ff : q_ff;
               mb = neg_r_ff ? -acc_ff : acc_ff;
               lo_in = w32_ff ? iahl_pkg::sx32(ma[31:0]) : ma;
               hi_in = w32_ff ? iahl_pkg::sx32(mb[31:0]) : mb;
            end else begin
               prod = {acc_ff, q_ff};
               if (neg_q_ff) prod = -prod;
               lo_in = w32_ff ? iahl_pkg::sx32(prod[31:0]) : prod[63:0];
               hi_in = w32_ff ? iahl_pkg::sx32(prod[63:32]) : prod[127:64];
            end
            res_in = '0; wr_in = 1'b0; exc_in = iahl_pkg::EXC_NONE;
            state_in = iahl_pkg::ST_DONE;
         end
         iahl_pkg::ST_DONE: begin
            if (rsp_tready) begin
               busy_in = 1'b0;
               state_in = iahl_pkg::ST_IDLE;
            end
         end
         default: state_in = iahl_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == iahl_pkg::ST_DONE);
   assign rsp_tdata  = {4'd0, exc_ff, wr_ff, res_ff};

   `IAHL_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, !rsp_tvalid)
   `IAHL_ASSERT_IMP(a_wr_noexc, clock, reset, rsp_tvalid && wr_ff, exc_ff == iahl_pkg::EXC_NONE)
   `IAHL_ASSERT_IMP(a_busy, clock, reset, rsp_tvalid, busy_ff)
   `IAHL_ASSERT_NEXT(a_accept, clock, reset, req_tvalid && req_tready,
      state_ff == iahl_pkg::ST_EXEC)

endmodule

// ----- tb/sv/integer_alu_hi_lo_trap_core_test.sv -----
// Self-checking testbench for the integer ALU with HI/LO registers and traps.
module integer_alu_hi_lo_trap_core_test;

   localparam int CycleLimitC = 400000;

   typedef struct packed {
      logic [63:0] rd_result;
      logic        rd_write;
      logic [2:0]  exc;
   } alu_result_type;

   // Scoreboard: carries its own HI/LO copy and the queue of expected words.
   class alu_scoreboard_type;
      logic [63:0]     hi_q, lo_q;
      alu_result_type  pending[$];
      int              errors;

      function new();
         hi_q = '0;
         lo_q = '0;
         errors = 0;
      endfunction

      function logic [63:0] sext(input logic [31:0] x);
         return {{32{x[31]}}, x};
      endfunction

      function logic [63:0] ashr(input logic [63:0] x, input int s);
         return $signed(x) >>> s;
      endfunction

      // Predict one instruction and queue its result.
      function void note_word(input logic [5:0] op, input logic [63:0] a, b,
                              input logic [4:0] sa);
         logic [63:0]     res, q, r;
         logic [31:0]     a32, b32;
         logic [127:0]    prod;
         logic [63:0]     ma, mb;
         logic            wr;
         logic [2:0]      exc;
         alu_result_type  e;
         res = '0; wr = 0; exc = iahl_pkg::EXC_NONE;
         a32 = a[31:0]; b32 = b[31:0];
         case (op)
            iahl_pkg::OP_ADD: begin
               res = sext(a32 + b32);
               if ((a32[31] == b32[31]) && (res[31] != a32[31]))
                  exc = iahl_pkg::EXC_OVERFLOW;
               else wr = 1;
            end
            iahl_pkg::OP_ADDU: begin res = sext(a32 + b32); wr = 1; end
            iahl_pkg::OP_AND: begin res = a & b; wr = 1; end
            iahl_pkg::OP_BREAK: exc = iahl_pkg::EXC_BREAK;
            iahl_pkg::OP_DADD: begin
               res = a + b;
               if ((a[63] == b[63]) && (res[63] != a[63])) exc = iahl_pkg::EXC_OVERFLOW;
               else wr = 1;
            end
            iahl_pkg::OP_DADDU: begin res = a + b; wr = 1; end
            iahl_pkg::OP_DDIV, iahl_pkg::OP_DIV: begin
               if (op == iahl_pkg::OP_DIV) begin ma = sext(a32); mb = sext(b32); end
               else begin ma = a; mb = b; end
               if (mb != 0) begin
                  q = (ma[63] ? -ma : ma) / (mb[63] ? -mb : mb);
                  r = (ma[63] ? -ma : ma) % (mb[63] ? -mb : mb);
                  if (ma[63] != mb[63]) q = -q;
                  if (ma[63]) r = -r;
                  if (op == iahl_pkg::OP_DIV) begin
                     q = sext(q[31:0]); r = sext(r[31:0]);
                  end
                  lo_q = q; hi_q = r;
               end
            end
            iahl_pkg::OP_DDIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
            iahl_pkg::OP_DIVU: if (b32 != 0) begin
               lo_q = sext(a32 / b32); hi_q = sext(a32 % b32);
            end
            iahl_pkg::OP_DMULT: begin
               prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
               lo_q = prod[63:0]; hi_q = prod[127:64];
            end
            iahl_pkg::OP_DMULTU: begin
               prod = {64'd0, a} * {64'd0, b};
               lo_q = prod[63:0]; hi_q = prod[127:64];
            end
            iahl_pkg::OP_DSLL: begin res = b << sa; wr = 1; end
            iahl_pkg::OP_DSLL32: begin res = b << (sa + 32); wr = 1; end
            iahl_pkg::OP_DSLLV: begin res = b << a[5:0]; wr = 1; end
            iahl_pkg::OP_DSRA: begin res = ashr(b, sa); wr = 1; end
            iahl_pkg::OP_DSRA32: begin res = ashr(b, sa + 32); wr = 1; end
            iahl_pkg::OP_DSRAV: begin res = ashr(b, a[5:0]); wr = 1; end
            iahl_pkg::OP_DSRL: begin res = b >> sa; wr = 1; end
            iahl_pkg::OP_DSRL32: begin res = b >> (sa + 32); wr = 1; end
            iahl_pkg::OP_DSRLV: begin res = b >> a[5:0]; wr = 1; end
            iahl_pkg::OP_DSUB: begin
               res = a - b;
               if ((a[63] != b[63]) && (res[63] != a[63])) exc = iahl_pkg::EXC_OVERFLOW;
               else wr = 1;
            end
            iahl_pkg::OP_DSUBU: begin res = a - b; wr = 1; end
            iahl_pkg::OP_MFHI: begin res = hi_q; wr = 1; end
            iahl_pkg::OP_MFLO: begin res = lo_q; wr = 1; end
            iahl_pkg::OP_MTHI: hi_q = a;
            iahl_pkg::OP_MTLO: lo_q = a;
            iahl_pkg::OP_MULT: begin
               res = sext(a32) * sext(b32);
               lo_q = sext(res[31:0]); hi_q = sext(res[63:32]); res = '0;
            end
            iahl_pkg::OP_MULTU: begin
               res = {32'd0, a32} * {32'd0, b32};
               lo_q = sext(res[31:0]); hi_q = sext(res[63:32]); res = '0;
            end
            iahl_pkg::OP_NOR: begin res = ~(a | b); wr = 1; end
            iahl_pkg::OP_OR: begin res = a | b; wr = 1; end
            iahl_pkg::OP_SLL: begin res = sext(b32 << sa); wr = 1; end
            iahl_pkg::OP_SLLV: begin res = sext(b32 << a[4:0]); wr = 1; end
            iahl_pkg::OP_SLT: begin res = {63'd0, $signed(a) < $signed(b)}; wr = 1; end
            iahl_pkg::OP_SLTU: begin res = {63'd0, a < b}; wr = 1; end
            iahl_pkg::OP_SRA: begin res = ashr(sext(b32), sa); wr = 1; end
            iahl_pkg::OP_SRAV: begin res = ashr(sext(b32), a[4:0]); wr = 1; end
            iahl_pkg::OP_SRL: begin res = sext(b32 >> sa); wr = 1; end
            iahl_pkg::OP_SRLV: begin res = sext(b32 >> a[4:0]); wr = 1; end
            iahl_pkg::OP_SUB: begin
               res = sext(a32 - b32);
               if ((a32[31] != b32[31]) && (res[31] != a32[31]))
                  exc = iahl_pkg::EXC_OVERFLOW;
               else wr = 1;
            end
            iahl_pkg::OP_SUBU: begin res = sext(a32 - b32); wr = 1; end
            iahl_pkg::OP_SYSCALL: exc = iahl_pkg::EXC_SYSCALL;
            iahl_pkg::OP_TEQ: if (a == b) exc = iahl_pkg::EXC_TRAP;
            iahl_pkg::OP_TGE: if (!($signed(a) < $signed(b))) exc = iahl_pkg::EXC_TRAP;
            iahl_pkg::OP_TGEU: if (a >= b) exc = iahl_pkg::EXC_TRAP;
            iahl_pkg::OP_TLT: if ($signed(a) < $signed(b)) exc = iahl_pkg::EXC_TRAP;
            iahl_pkg::OP_TLTU: if (a < b) exc = iahl_pkg::EXC_TRAP;
            iahl_pkg::OP_TNE: if (a != b) exc = iahl_pkg::EXC_TRAP;
            iahl_pkg::OP_XOR: begin res = a ^ b; wr = 1; end
            default: ;
         endcase
         e.rd_result = wr ? res : '0;
         e.rd_write = wr;
         e.exc = exc;
         pending.push_back(e);
      endfunction

      task report(input string what, input logic [63:0] got, exp);
         errors++;
         $display("mismatch %s: got %h expected %h", what, got, exp);
      endtask

      task check_word(input logic [71:0] d);
         alu_result_type e;
         if (pending.size() == 0) begin
            report("unexpected word", d[63:0], 64'd0);
            return;
         end
         e = pending.pop_front();
         if (d[63:0] !== e.rd_result) report("rd_result", d[63:0], e.rd_result);
         if (d[64] !== e.rd_write) report("rd_write", 64'(d[64]), 64'(e.rd_write));
         if (d[67:65] !== e.exc) report("exception_code", 64'(d[67:65]), 64'(e.exc));
      endtask
   endclass

   logic                clock, reset;
   logic                req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [143:0]        req_tdata;
   logic [71:0]         rsp_tdata;
   alu_scoreboard_type  sb;
   int                  cycles;
   bit                  hold_off;

   integer_alu_hi_lo_trap_core u_top (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimitC) begin
            $display("integer_alu_hi_lo_trap_core_test failed");
            $finish;
         end
      end
   end

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'h7FFF_FFFF_FFFF_FFFF;
         3: return '1;
         4: return {{32{1'b0}}, 32'h8000_0000};
         5: return {{32{1'b0}}, 32'h7FFF_FFFF};
         6: return 64'($urandom_range(0, 40));
         7: return {32'd0, $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Keep tvalid high into the next word when the drawn gap is zero.
   task send_word(input logic [5:0] op, input logic [63:0] a, b, input logic [4:0] sa);
      int gap;
      gap = $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, sa, b, a, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(op, a, b, sa);
   endtask

   // Receiver: drawn wait per word plus one long hold-off.
   initial begin
      int wait_cnt;
      rsp_tready = 0;
      wait_cnt = $urandom_range(0, 14);
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_word(rsp_tdata);
            wait_cnt = $urandom_range(0, 14);
         end
         if (hold_off) rsp_tready <= 0;
         else if (wait_cnt != 0) begin
            wait_cnt--;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   initial begin
      hold_off = 0;
      repeat (300) @(posedge clock);
      hold_off <= 1;
      repeat (400) @(posedge clock);
      hold_off <= 0;
   end

   initial begin
      logic [63:0] a, b;
      logic [5:0]  op;
      int          n;
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: every third op on extremes, then the named corner cases.
      for (int i = 0; i < 50; i += 3)
         send_word(i[5:0], 64'h8000_0000_0000_0000, '1, 5'd31);
      send_word(iahl_pkg::OP_DDIV, 64'h8000_0000_0000_0000, '1, 5'd0);
      send_word(iahl_pkg::OP_MFLO, 64'd0, 64'd0, 5'd0);
      send_word(iahl_pkg::OP_DIV, 64'h8000_0000, 64'hFFFF_FFFF, 5'd0);
      send_word(iahl_pkg::OP_MFHI, 64'd0, 64'd0, 5'd0);
      send_word(iahl_pkg::OP_DDIVU, 64'd7, 64'd0, 5'd0);
      send_word(iahl_pkg::OP_MFLO, 64'd0, 64'd0, 5'd0);
      send_word(iahl_pkg::OP_ADD, 64'h7FFF_FFFF, 64'd1, 5'd0);
      send_word(iahl_pkg::OP_DSUB, 64'h8000_0000_0000_0000, 64'd1, 5'd0);
      send_word(6'd63, '1, '1, 5'd31);
      n = 0;
      while (n < 850) begin
         op = $urandom_range(0, 9) == 0 ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, 49));
         a = pick_value();
         b = ($urandom_range(0, 5) == 0) ? a : pick_value();
         // Keep multiply/divide rarer: they iterate one bit at a time.
         if (op inside {[iahl_pkg::OP_DDIV:iahl_pkg::OP_DMULTU], iahl_pkg::OP_MULT,
                        iahl_pkg::OP_MULTU} && $urandom_range(0, 2) != 0)
            op = iahl_pkg::OP_MFHI + 6'($urandom_range(0, 3));
         send_word(op, a, b, 5'($urandom()));
         n++;
      end
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) $display("integer_alu_hi_lo_trap_core_test passed");
      else $display("integer_alu_hi_lo_trap_core_test failed");
      $finish;
   end

endmodule

// ----- integer_alu_hi_lo_trap_core.f -----
+incdir+rtl
rtl/iahl_pkg.sv
rtl/integer_alu_hi_lo_trap_core.sv
tb/sv/integer_alu_hi_lo_trap_core_test.sv
